// ===== hdl/aes_pkg.sv =====
`default_nettype none
package aes_pkg;
  localparam int unsigned RkDepth = 22;
  localparam int unsigned RkAw = 5;
  localparam int unsigned NumRounds = 10;

  typedef enum logic [1:0] {
    MODE_ECB = 2'd0,
    MODE_CBC = 2'd1,
    MODE_CTR = 2'd2,
    MODE_RSV = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_KEY_HIGH = 3'd0,
    REG_KEY_LOW  = 3'd1,
    REG_IV_HIGH  = 3'd2,
    REG_IV_LOW   = 3'd3,
    REG_NONCE    = 3'd4,
    REG_MODE     = 3'd5,
    REG_DIR      = 3'd6,
    REG_NONE     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic       start;
    logic       decrypt;
    logic [3:0] round;
    logic       first;
    logic       final_rnd;
  } rnd_ctl_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) r = r ^ x;
      x = xt(x);
    end
    gm = r;
  endfunction

  function automatic logic [7:0] inv8(input logic [7:0] x);
    logic [7:0] p;
    logic [7:0] sq;
    logic [7:0] t;
    p = 8'h01;
    sq = x;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) begin
        t = 8'h00;
        for (int k = 0; k < 8; k++) if (p[k]) t = t ^ sq;
        p = t;
      end
      t = 8'h00;
      for (int k = 0; k < 8; k++) begin
        if (sq[k]) t = t ^ gm8pow(sq, k);
      end
      sq = t;
    end
    inv8 = p;
  endfunction

  function automatic logic [7:0] gm8pow(input logic [7:0] a, input int k);
    logic [7:0] x;
    x = a;
    for (int i = 0; i < 8; i++) if (i < k) x = xt(x);
    gm8pow = x;
  endfunction

  function automatic logic [7:0] gmf(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ x;
      x = xt(x);
    end
    gmf = r;
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] p;
    logic [7:0] v;
    p = 8'h01;
    for (int k = 0; k < 254; k++) p = gmf(p, x);
    v = (x == 8'h00) ? 8'h00 : p;
    sbox = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
         ^ {v[3:0], v[7:4]} ^ 8'h63;
  endfunction

  typedef logic [7:0] box_t [256];

  function automatic box_t fwd_table();
    box_t t;
    for (int i = 0; i < 256; i++) t[i] = sbox(8'(i));
    return t;
  endfunction

  function automatic box_t inv_table();
    box_t t;
    for (int i = 0; i < 256; i++) t[sbox(8'(i))] = 8'(i);
    return t;
  endfunction

  localparam box_t FwdBox = fwd_table();
  localparam box_t InvBox = inv_table();
endpackage
`default_nettype wire

// ===== hdl/aes_ram.sv =====
`default_nettype none
module aes_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 22,
  parameter int unsigned Aw = 5
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [Aw-1:0]    waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [Aw-1:0]    raddr,
  output logic      [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/aes_round.sv =====
`default_nettype none
module aes_round (
  input  wire logic [127:0]       state_in,
  input  wire logic [127:0]       rkey,
  input  wire aes_pkg::rnd_ctl_t  ctl,
  output logic      [127:0]       state_out
);
  import aes_pkg::*;

  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] u [16];
  logic [7:0] k [16];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_in[127-8*i -: 8];
      k[i] = rkey[127-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) begin
      t[i] = s[i];
      u[i] = s[i];
    end
    if (ctl.first) begin
      for (int i = 0; i < 16; i++) u[i] = s[i] ^ k[i];
    end else if (!ctl.decrypt) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++)
          t[i+4*c] = FwdBox[s[i+4*((c+i)%4)]];
      for (int c = 0; c < 4; c++) begin
        if (ctl.final_rnd) begin
          for (int i = 0; i < 4; i++) u[4*c+i] = t[4*c+i];
        end else begin
          u[4*c]   = xt(t[4*c]) ^ xt(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
          u[4*c+1] = t[4*c] ^ xt(t[4*c+1]) ^ xt(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
          u[4*c+2] = t[4*c] ^ t[4*c+1] ^ xt(t[4*c+2]) ^ xt(t[4*c+3]) ^ t[4*c+3];
          u[4*c+3] = xt(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xt(t[4*c+3]);
        end
      end
      for (int i = 0; i < 16; i++) u[i] = u[i] ^ k[i];
    end else begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++)
          t[i+4*((c+i)%4)] = InvBox[s[i+4*c]] ^ k[i+4*((c+i)%4)];
      for (int c = 0; c < 4; c++) begin
        if (ctl.final_rnd) begin
          for (int i = 0; i < 4; i++) u[4*c+i] = t[4*c+i];
        end else begin
          u[4*c]   = gm(t[4*c], 4'd14) ^ gm(t[4*c+1], 4'd11)
                   ^ gm(t[4*c+2], 4'd13) ^ gm(t[4*c+3], 4'd9);
          u[4*c+1] = gm(t[4*c], 4'd9) ^ gm(t[4*c+1], 4'd14)
                   ^ gm(t[4*c+2], 4'd11) ^ gm(t[4*c+3], 4'd13);
          u[4*c+2] = gm(t[4*c], 4'd13) ^ gm(t[4*c+1], 4'd9)
                   ^ gm(t[4*c+2], 4'd14) ^ gm(t[4*c+3], 4'd11);
          u[4*c+3] = gm(t[4*c], 4'd11) ^ gm(t[4*c+1], 4'd13)
                   ^ gm(t[4*c+2], 4'd9) ^ gm(t[4*c+3], 4'd14);
        end
      end
    end
    for (int i = 0; i < 16; i++) state_out[127-8*i -: 8] = u[i];
  end
endmodule
`default_nettype wire

// ===== hdl/aes128_block_mode_engine.sv =====
`default_nettype none
// AES-128 block engine for ECB, CBC and CTR with PKCS7 padding on ECB/CBC.
// One round at a time through a single shared round unit. Each 128-bit round
// key is read from the key store as two 64-bit halves, one after the other.
// A block runs from its accepting edge to its result through state setup,
// round key fetch, eleven rounds and an output step. The first block after a
// key write adds a 44-word key expansion (one word a cycle). An ECB/CBC
// encrypt last block that is full gives two results; its pad block starts
// once the first result is transferred and skips the state setup step.
// The input is not ready while a block is in progress, its result waits or
// a pad block is pending.
module aes128_block_mode_engine (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [135:0] s_axis_tdata,  // block_high, block_low, byte_count, pad
  input  wire logic         s_axis_tlast,  // last_block
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [135:0] m_axis_tdata,  // result_high, result_low, valid_bytes, pad
  output logic              m_axis_tlast,  // end_of_message
  output logic              m_axis_tuser,  // pad_error
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);
  import aes_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_KEXP, ST_LOAD, ST_RND, ST_FIN, ST_OUT
  } st_t;

  st_t st;
  logic [127:0] key, iv, chain, state, blk;
  logic [63:0]  nonce, bctr;
  logic [1:0]   mode;
  logic         dir, keys_ready, in_msg;
  logic [4:0]   n;
  logic         last, second, extra, dec_now;
  logic [3:0]   rnd;
  logic [5:0]   kw;
  logic [31:0]  w [4];
  logic [7:0]   rcon;
  logic         half;
  logic [63:0]  rk_hi;

  logic         rk_we;
  logic [RkAw-1:0] rk_wa, rk_ra;
  logic [63:0]  rk_wd, rk_rd;

  aes_ram #(.Width(64), .Depth(RkDepth), .Aw(RkAw)) u_rk (
    .clk(clk), .we(rk_we), .waddr(rk_wa), .wdata(rk_wd), .raddr(rk_ra), .rdata(rk_rd)
  );

  rnd_ctl_t ctl;
  logic [127:0] rnd_out;
  aes_round u_rnd (.state_in(state), .rkey({rk_hi, rk_rd}), .ctl(ctl), .state_out(rnd_out));

  assign cfg_ready = (st == ST_IDLE) && !m_axis_tvalid && !second;
  assign s_axis_tready = (st == ST_IDLE) && !m_axis_tvalid && !second;

  logic [31:0] kt;
  always_comb begin
    kt = {w[3][23:0], w[3][31:24]};
    kt = {FwdBox[kt[31:24]], FwdBox[kt[23:16]], FwdBox[kt[15:8]], FwdBox[kt[7:0]]}
       ^ {rcon, 24'h0};
  end

  // key word writes: two words per 64-bit entry
  logic [31:0] wn;
  assign wn = (kw[1:0] == 2'd0) ? (w[0] ^ kt) : (w[0] ^ w[3]);
  assign rk_we = (st == ST_KEXP) && kw[0];
  assign rk_wa = RkAw'((kw >> 1));
  assign rk_wd = (kw < 6'd4) ? (kw[1] ? {w[2], w[3]} : {w[0], w[1]}) : {w[3], wn};

  // read address is set the cycle before its registered read data is used
  logic [3:0] rk_rnd, rk_idx;
  assign rk_rnd = (st == ST_RND && !half && rnd != 4'(NumRounds)) ? rnd + 4'd1 : rnd;
  assign rk_idx = dec_now ? 4'(NumRounds) - rk_rnd : rk_rnd;
  assign rk_ra = half ? RkAw'({rk_idx, 1'b1}) : RkAw'({rk_idx, 1'b0});

  assign ctl.start = 1'b0;
  assign ctl.decrypt = dec_now;
  assign ctl.round = rnd;
  assign ctl.first = (rnd == 4'd0);
  assign ctl.final_rnd = (rnd == 4'(NumRounds));

  function automatic logic [127:0] bswap_le(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] r;
    for (int i = 0; i < 8; i++) begin
      r[127-8*i -: 8] = a[8*i +: 8];
      r[63-8*i -: 8] = b[8*i +: 8];
    end
    return r;
  endfunction

  logic [127:0] fin, padded, mask_res;
  logic [4:0] vb;
  logic err;
  logic [7:0] p;
  logic need_pad;
  assign need_pad = (mode != MODE_CTR) && !dec_now && last && (n == 5'd16) && !extra;

  always_comb begin
    fin = state;
    padded = blk;
    for (int i = 0; i < 16; i++)
      if (5'(i) >= n) padded[127-8*i -: 8] = 8'(5'd16 - n);
    mask_res = 128'h0;
    vb = 5'd16;
    err = 1'b0;
    p = 8'h00;
    if (mode == MODE_CTR) begin
      for (int i = 0; i < 16; i++)
        if (5'(i) < n) mask_res[127-8*i -: 8] = blk[127-8*i -: 8] ^ fin[127-8*i -: 8];
      vb = n;
    end else if (dec_now) begin
      mask_res = (mode == MODE_CBC) ? (fin ^ chain) : fin;
      p = mask_res[7:0];
      if (last) begin
        if (p > 8'd16) err = 1'b1;
        else begin
          for (int i = 0; i < 16; i++)
            if (5'(i) >= 5'd16 - p[4:0] && mask_res[127-8*i -: 8] != p) err = 1'b1;
          if (!err) vb = 5'd16 - p[4:0];
        end
      end
    end else begin
      mask_res = fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      key <= '0; iv <= '0; nonce <= '0; mode <= 2'd0; dir <= 1'b0;
      keys_ready <= 1'b0; in_msg <= 1'b0; bctr <= '0; chain <= '0;
      m_axis_tvalid <= 1'b0;
      second <= 1'b0; extra <= 1'b0;
      half <= 1'b0; rnd <= '0; kw <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_KEY_HIGH: begin key[127:64] <= cfg_data; keys_ready <= 1'b0; end
          REG_KEY_LOW:  begin key[63:0] <= cfg_data; keys_ready <= 1'b0; end
          REG_IV_HIGH:  iv[127:64] <= cfg_data;
          REG_IV_LOW:   iv[63:0] <= cfg_data;
          REG_NONCE:    nonce <= cfg_data;
          REG_MODE:     mode <= cfg_data[1:0];
          REG_DIR:      dir <= cfg_data[0];
          default: ;
        endcase
      end
      case (st)
        ST_IDLE: begin
          if (second && !m_axis_tvalid) begin
            second <= 1'b0;
            extra <= 1'b1;
            blk <= {128{1'b0}} | {16{8'h10}};
            n <= 5'd16;
            state <= {16{8'h10}} ^ ((mode == MODE_CBC) ? chain : 128'h0);
            last <= 1'b1;
            rnd <= '0; half <= 1'b0;
            st <= ST_LOAD;
          end else if (s_axis_tvalid && s_axis_tready) begin
            blk <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
            last <= s_axis_tlast;
            n <= (!s_axis_tlast || s_axis_tdata[132:128] > 5'd16) ? 5'd16
               : s_axis_tdata[132:128];
            in_msg <= !s_axis_tlast;
            if (!in_msg) begin
              chain <= iv;
              bctr <= '0;
            end
            dec_now <= (mode != MODE_CTR) && dir;
            second <= 1'b0;
            extra <= 1'b0;
            w[0] <= key[127:96]; w[1] <= key[95:64];
            w[2] <= key[63:32]; w[3] <= key[31:0];
            rcon <= 8'h01; kw <= '0;
            rnd <= '0; half <= 1'b0;
            st <= keys_ready ? ST_FIN : ST_KEXP;
          end
        end
        ST_KEXP: begin
          // produce key words 0..43 one a cycle, writing them in pairs
          if (kw >= 6'd4) begin
            w[0] <= w[1]; w[1] <= w[2]; w[2] <= w[3]; w[3] <= wn;
            if (kw[1:0] == 2'd0) rcon <= xt(rcon);
          end
          kw <= kw + 6'd1;
          if (kw == 6'd43) begin
            keys_ready <= 1'b1;
            st <= ST_FIN;
          end
        end
        ST_FIN: begin
          // build the first state
          if (mode == MODE_CTR) state <= bswap_le(nonce, bctr);
          else if (dec_now) state <= blk;
          else state <= ((last && n < 5'd16) ? padded : blk)
                      ^ ((mode == MODE_CBC) ? chain : 128'h0);
          st <= ST_LOAD;
        end
        ST_LOAD: begin
          half <= 1'b1;
          st <= ST_RND;
        end
        ST_RND: begin
          if (half) begin
            rk_hi <= rk_rd;
            half <= 1'b0;
          end else begin
            state <= rnd_out;
            if (rnd == 4'(NumRounds)) begin
              st <= ST_OUT;
            end else begin
              rnd <= rnd + 4'd1;
              half <= 1'b1;
            end
          end
        end
        ST_OUT: begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata <= {3'b000, vb, mask_res[63:0], mask_res[127:64]};
          m_axis_tuser <= err;
          m_axis_tlast <= last && !need_pad;
          second <= need_pad;
          if (mode == MODE_CTR) bctr <= bctr + 64'd1;
          if (mode == MODE_CBC) chain <= dec_now ? blk : fin;
          st <= ST_IDLE;
        end
        default: st <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
